/* rtl/core/scaler_channel_running_stats_unit_assert.svh */
// Assertion macros for the scaler channel running statistics unit.
// Used by the port checker; needs clk and rst_n in the using scope.
`ifndef SCALER_CHANNEL_RUNNING_STATS_UNIT_ASSERT_SVH
`define SCALER_CHANNEL_RUNNING_STATS_UNIT_ASSERT_SVH
// clocked assertion, disabled in reset
`define SCRS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("scrs port check failed");
// same, also checked during reset
`define SCRS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("scrs port check failed");
`endif

/* rtl/core/scrs_pkg.sv */
// Shared types and constants of the scaler channel running statistics unit.
// No dependencies.
package scrs_pkg;
  localparam int StW = 4;
  localparam logic [StW-1:0] ST_IDLE = 4'd0;
  localparam logic [StW-1:0] ST_PREP = 4'd1;
  localparam logic [StW-1:0] ST_MULC = 4'd2;
  localparam logic [StW-1:0] ST_CUT  = 4'd3;
  localparam logic [StW-1:0] ST_D1   = 4'd4;
  localparam logic [StW-1:0] ST_DIVW = 4'd5;
  localparam logic [StW-1:0] ST_D2   = 4'd6;
  localparam logic [StW-1:0] ST_MULW = 4'd7;
  localparam logic [StW-1:0] ST_UPD  = 4'd8;
  localparam logic [StW-1:0] ST_DONE = 4'd9;

  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_MASK24 = 3'd1;
  localparam logic [2:0] REG_PED    = 3'd2;
  localparam logic [2:0] REG_GAIN   = 3'd3;
  localparam logic [2:0] REG_CUT    = 3'd4;
  localparam logic [2:0] REG_UPPER  = 3'd5;
  localparam logic [2:0] REG_LOWER  = 3'd6;

  localparam logic [31:0] MASK24   = 32'h00ff_ffff;
  localparam logic [31:0] MASK32   = 32'hffff_ffff;
  localparam logic [31:0] GAIN_ONE = 32'd65536;
  localparam logic [62:0] MAX63    = {63{1'b1}};
  localparam logic [63:0] SIGN64   = {1'b1, 63'd0};
  localparam logic [6:0]  STEPS    = 7'd64;

  typedef struct packed {
    logic start;
    logic div;
  } md_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] hi;
    logic [63:0] lo;
  } md_rsp_t;
endpackage

/* rtl/core/scrs_muldiv.sv */
// Radix-2 shared multiply / divide unit, one add or subtract per cycle.
// Depends on scrs_pkg.
module scrs_muldiv (
  input  logic              clk,
  input  logic              rst_n,
  input  scrs_pkg::md_req_t req,
  input  logic [63:0]       opa,   // multiplicand or dividend
  input  logic [63:0]       opb,   // multiplier or divisor
  output scrs_pkg::md_rsp_t rsp
);
  import scrs_pkg::*;

  logic [6:0]  cnt_r;
  logic        div_r;
  logic        done_r;
  logic [63:0] hi_r, lo_r, opnd_r;
  logic [63:0] hi_nxt, lo_nxt;
  logic [64:0] shifted, t;
  logic [65:0] addend, sum;
  logic        ge;

  always_comb begin
    shifted = div_r ? {hi_r, lo_r[63]} : {1'b0, hi_r};
    addend  = div_r ? ~{2'b00, opnd_r} : {2'b00, opnd_r};
    sum     = {1'b0, shifted} + addend + {65'd0, div_r};
    ge      = !sum[65];
    t       = lo_r[0] ? sum[64:0] : {1'b0, hi_r};
    if (div_r) begin
      hi_nxt = ge ? sum[63:0] : shifted[63:0];
      lo_nxt = {lo_r[62:0], ge};
    end else begin
      hi_nxt = t[64:1];
      lo_nxt = {t[0], lo_r[63:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 7'd0;
      done_r <= 1'b0;
      div_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        cnt_r <= STEPS;
        div_r <= req.div;
      end else if (cnt_r != 7'd0) begin
        cnt_r  <= cnt_r - 7'd1;
        done_r <= (cnt_r == 7'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      hi_r   <= 64'd0;
      // mul: lo holds multiplier; div: lo holds dividend
      lo_r   <= req.div ? opa : opb;
      opnd_r <= req.div ? opb : opa;
    end else if (cnt_r != 7'd0) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.hi   = hi_r;
  assign rsp.lo   = lo_r;
endmodule

/* rtl/core/scaler_channel_running_stats_unit.sv */
// Scaler channel calibration, cuts and Welford running mean / M2.
// Top level; depends on scrs_pkg and scrs_muldiv.
//
// Input channel in_*: one 32-bit raw scaler word per event. The block takes
// one word at a time; in_tready is high only while the sequencer is idle.
// Output channel out_*: one result word per input word, held in an output
// register until taken. The next input word is accepted while that result
// waits; if the following result is ready before the old one is taken, the
// sequencer holds it until out_tready.
// A disabled channel goes straight to the output register; a flagged event
// runs one 64-step multiply for the calibration, and an accumulated event
// adds a 64-step divide and a 64-step multiply on the same radix-2 unit.
// in_tready rises together with out_tvalid, so the block takes no new word
// until the previous one has left the single shared unit and reached the
// output register.
// A stall on out_tready only adds cycles when a finished result must wait.
// cfg_*: register writes; write only while no word is in flight.
// Reset (rst_n low, synchronous) restores the register defaults, clears the
// count, mean and M2, and empties the output register.
module scaler_channel_running_stats_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // raw_word
  output logic         out_tvalid,
  input  logic         out_tready,
  // calibrated_value[63:0], good_count[95:64], running_mean[159:96],
  // running_m2[222:160], zero pad [223]
  output logic [223:0] out_tdata,
  // error_flags[2:0], event_pass[3], accumulated[4]
  output logic [4:0]   out_tuser,
  input  logic         cfg_wr_en,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_wdata
);
  import scrs_pkg::*;

  logic            enable_r, mask24_r;
  logic [63:0]     ped_r, upper_r, lower_r;
  logic [31:0]     gain_r;
  logic [1:0]      cut_r;
  logic [StW-1:0]  state_r;
  logic [31:0]     raw_r, count_r;
  logic [63:0]     v_r, mean_r, d1_r, nm_r;
  logic [62:0]     m2_r, p_r;
  logic            neg_r, pos_r, pass_r, acc_r;
  logic [2:0]      flags_r;

  md_req_t     req;
  md_rsp_t     rsp;
  logic [63:0] md_a, md_b;

  logic [63:0] rfx, mag_w, r_w, d1_w, d2_w, cal_w;
  logic        big_w, pos_w, le_u, le_l;
  logic [2:0]  flags_w;
  logic        pass_w;
  logic [63:0] m2_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
      mask24_r <= 1'b0;
      ped_r    <= 64'd0;
      gain_r   <= GAIN_ONE;
      cut_r    <= 2'd0;
      upper_r  <= 64'd0;
      lower_r  <= 64'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ENABLE: enable_r <= cfg_wdata[0];
        REG_MASK24: mask24_r <= cfg_wdata[0];
        REG_PED:    ped_r    <= cfg_wdata;
        REG_GAIN:   gain_r   <= cfg_wdata[31:0];
        REG_CUT:    cut_r    <= cfg_wdata[1:0];
        REG_UPPER:  upper_r  <= cfg_wdata;
        REG_LOWER:  lower_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    rfx   = {16'd0, raw_r, 16'd0};
    mag_w = (ped_r[63] || rfx >= ped_r) ? rfx - ped_r : ped_r - rfx;
    // product bits 79:16, overflow when anything above bit 79 is set
    big_w = |rsp.hi[63:16];
    r_w   = {rsp.hi[15:0], rsp.lo[63:16]};
    if (!neg_r) cal_w = (big_w || r_w[63]) ? {1'b0, MAX63} : r_w;
    else cal_w = (big_w || (r_w[63] && |r_w[62:0])) ? SIGN64 : 64'd0 - r_w;

    le_u    = $signed(v_r) <= $signed(upper_r);
    le_l    = $signed(lower_r) <= $signed(v_r);
    flags_w = 3'd0;
    pass_w  = 1'b1;
    if (cut_r != 2'd0 && raw_r == 32'd0) flags_w[0] = 1'b1;
    if (cut_r[1] && !(upper_r == 64'd0 && lower_r == 64'd0) && !(le_u && le_l)) begin
      if (!le_u) flags_w[1] = 1'b1;
      else flags_w[2] = 1'b1;
      pass_w = 1'b0;
    end
    if (cut_r == 2'd3) pass_w = 1'b1;

    pos_w  = $signed(mean_r) <= $signed(v_r);
    d1_w   = pos_w ? v_r - mean_r : mean_r - v_r;
    d2_w   = pos_r ? v_r - nm_r : nm_r - v_r;
    m2_sum = {1'b0, m2_r} + {1'b0, p_r};

    req.start = 1'b0;
    req.div   = 1'b0;
    md_a      = {32'd0, gain_r};
    md_b      = mag_w;
    unique case (state_r)
      ST_PREP: req.start = 1'b1;
      ST_D1: begin
        req.start = 1'b1;
        req.div   = 1'b1;
        md_a      = d1_w;
        md_b      = {31'd0, {1'b0, count_r} + 33'd1};
      end
      ST_D2: begin
        req.start = 1'b1;
        md_a      = d1_r;
        md_b      = d2_w;
      end
      default: ;
    endcase
  end

  scrs_muldiv u_md (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .opa  (md_a),
    .opb  (md_b),
    .rsp  (rsp)
  );

  assign in_tready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      count_r    <= 32'd0;
      mean_r     <= 64'd0;
      m2_r       <= 63'd0;
      out_tvalid <= 1'b0;
    end else begin
      if (state_r == ST_DONE && (!out_tvalid || out_tready)) out_tvalid <= 1'b1;
      else if (out_tready) out_tvalid <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            raw_r   <= in_tdata & (mask24_r ? MASK24 : MASK32);
            v_r     <= 64'd0;
            flags_r <= 3'd0;
            pass_r  <= 1'b0;
            acc_r   <= 1'b0;
            state_r <= enable_r ? ST_PREP : ST_DONE;
          end
        end
        ST_PREP: begin
          neg_r   <= !(ped_r[63] || rfx >= ped_r);
          state_r <= ST_MULC;
        end
        ST_MULC: begin
          if (rsp.done) begin
            v_r     <= cal_w;
            state_r <= ST_CUT;
          end
        end
        ST_CUT: begin
          flags_r <= flags_w;
          pass_r  <= pass_w;
          state_r <= (flags_w == 3'd0) ? ST_D1 : ST_DONE;
        end
        ST_D1: begin
          pos_r   <= pos_w;
          d1_r    <= d1_w;
          state_r <= ST_DIVW;
        end
        ST_DIVW: begin
          if (rsp.done) begin
            nm_r    <= pos_r ? mean_r + rsp.lo : mean_r - rsp.lo;
            state_r <= ST_D2;
          end
        end
        ST_D2: state_r <= ST_MULW;
        ST_MULW: begin
          if (rsp.done) begin
            p_r     <= (big_w || r_w[63]) ? MAX63 : r_w[62:0];
            state_r <= ST_UPD;
          end
        end
        ST_UPD: begin
          m2_r    <= m2_sum[63] ? MAX63 : m2_sum[62:0];
          mean_r  <= nm_r;
          if (count_r != MASK32) count_r <= count_r + 32'd1;
          acc_r   <= 1'b1;
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_tvalid || out_tready) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && (!out_tvalid || out_tready)) begin
      out_tdata <= {1'b0, m2_r, mean_r, count_r, v_r};
      out_tuser <= {acc_r, pass_r, flags_r};
    end
  end
endmodule

/* rtl/core/scrs_checker.sv */
// Port-level checker for the scaler channel running statistics unit, bound
// to the top level. Depends on scaler_channel_running_stats_unit_assert.svh.
`include "scaler_channel_running_stats_unit_assert.svh"
module scrs_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [223:0] out_tdata,
  input logic [4:0]   out_tuser
);
  // a stalled result word stays up
  `SCRS_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid)
  // one word in flight: ready drops right after an accept
  `SCRS_ASSERT(a_one_busy, in_tvalid && in_tready |=> !in_tready)
  // only clean events are accumulated, and they pass
  `SCRS_ASSERT(a_acc_clean, out_tvalid && out_tuser[4] |-> out_tuser[2:0] == 3'd0 && out_tuser[3])
  // an accumulated event leaves a nonzero count
  `SCRS_ASSERT(a_acc_count, out_tvalid && out_tuser[4] |-> out_tdata[95:64] != 32'd0)
endmodule

bind scaler_channel_running_stats_unit scrs_checker u_scrs_checker (.*);

/* sim/scaler_channel_running_stats_unit_checker.sv */
// Checker for the scaler channel running statistics unit: watches the input,
// output and register write ports, predicts each result word and compares.
// Depends on scrs_pkg for register indexes and constants.
module scaler_channel_running_stats_unit_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [31:0]  in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [223:0] out_tdata,
  input  logic [4:0]   out_tuser,
  input  logic         cfg_wr_en,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_wdata,
  output int           fail_count,
  output int           pending
);
  import scrs_pkg::*;

  typedef struct packed {
    logic [62:0] m2;
    logic [63:0] mean;
    logic [31:0] count;
    logic        acc;
    logic        pass;
    logic [2:0]  flags;
    logic [63:0] value;
  } stats_word_t;

  logic        en_r, m24_r;
  logic [63:0] ped_r, upper_r, lower_r;
  logic [31:0] gain_r;
  logic [1:0]  cut_r;
  logic [31:0] count_r;
  logic [63:0] mean_r;
  logic [62:0] m2_r;
  stats_word_t expected_q[$];

  assign pending = expected_q.size();

  // (a*b)>>16 with overflow flag when result needs more than 64 bits
  function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b,
                                         output logic big);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    big = |p[127:80];
    return p[79:16];
  endfunction

  function automatic logic [63:0] calibrate(input logic [31:0] raw);
    logic [63:0] rfx, mag, r;
    logic neg, big;
    rfx = {16'd0, raw, 16'd0};
    neg = 1'b0;
    if (ped_r[63]) mag = rfx - ped_r;
    else if (rfx >= ped_r) mag = rfx - ped_r;
    else begin
      mag = ped_r - rfx;
      neg = 1'b1;
    end
    r = fx_mul({32'd0, gain_r}, mag, big);
    if (!neg) return (big || r > {1'b0, MAX63}) ? {1'b0, MAX63} : r;
    return (big || r > SIGN64) ? SIGN64 : -r;
  endfunction

  function automatic stats_word_t predict_stats(input logic [31:0] word);
    stats_word_t e;
    logic [31:0] raw;
    logic [63:0] x, n, d1, q, nm, d2, p;
    logic pos, big;
    e = '0;
    if (en_r) begin
      raw = word & (m24_r ? MASK24 : MASK32);
      x = calibrate(raw);
      e.value = x;
      e.pass = 1'b1;
      if (cut_r >= 1 && raw == 0) e.flags[0] = 1'b1;
      if (cut_r >= 2 && !(upper_r == 0 && lower_r == 0)) begin
        if ($signed(x) > $signed(upper_r)) begin
          e.flags[1] = 1'b1;
          e.pass = 1'b0;
        end else if ($signed(x) < $signed(lower_r)) begin
          e.flags[2] = 1'b1;
          e.pass = 1'b0;
        end
      end
      if (cut_r == 2'd3) e.pass = 1'b1;
      if (e.flags == 0) begin
        n = {32'd0, count_r} + 64'd1;
        pos = $signed(mean_r) <= $signed(x);
        d1 = pos ? x - mean_r : mean_r - x;
        q = d1 / n;
        nm = pos ? mean_r + q : mean_r - q;
        d2 = pos ? x - nm : nm - x;
        p = fx_mul(d1, d2, big);
        if (big || p > {1'b0, MAX63}) p = {1'b0, MAX63};
        m2_r = (p[62:0] > MAX63 - m2_r) ? MAX63 : m2_r + p[62:0];
        mean_r = nm;
        if (count_r != MASK32) count_r = count_r + 1;
        e.acc = 1'b1;
      end
    end
    e.count = count_r;
    e.mean = mean_r;
    e.m2 = m2_r;
    return e;
  endfunction

  always @(posedge clk) begin
    stats_word_t got, want;
    if (!rst_n) begin
      en_r <= 1'b1; m24_r <= 1'b0; ped_r <= '0; gain_r <= GAIN_ONE;
      cut_r <= '0; upper_r <= '0; lower_r <= '0;
      count_r = '0; mean_r = '0; m2_r = '0;
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_ENABLE: en_r  <= cfg_wdata[0];
          REG_MASK24: m24_r <= cfg_wdata[0];
          REG_PED:    ped_r <= cfg_wdata;
          REG_GAIN:   gain_r <= cfg_wdata[31:0];
          REG_CUT:    cut_r <= cfg_wdata[1:0];
          REG_UPPER:  upper_r <= cfg_wdata;
          REG_LOWER:  lower_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) expected_q = {expected_q, predict_stats(in_tdata)};
      if (out_tvalid && out_tready) begin
        got = {out_tdata[222:160], out_tdata[159:96], out_tdata[95:64],
               out_tuser[4], out_tuser[3], out_tuser[2:0], out_tdata[63:0]};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch value exp %h got %h flags exp %b got %b",
                     $time, want.value, got.value, want.flags, got.flags);
            $display("%0t:   pass/acc exp %b%b got %b%b count exp %0d got %0d",
                     $time, want.pass, want.acc, got.pass, got.acc,
                     want.count, got.count);
            $display("%0t:   mean exp %h got %h m2 exp %h got %h",
                     $time, want.mean, got.mean, want.m2, got.m2);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

/* sim/scaler_channel_running_stats_unit_tb.sv */
// Testbench top: drives raw words and register settings into the scaler
// channel statistics unit; the checker module predicts and compares results.
// Depends on scrs_pkg, the unit and its checker.
module scaler_channel_running_stats_unit_tb;
  import scrs_pkg::*;

  // index past the register list, writes to it are dropped
  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic         clk, rst_n;
  logic         in_tvalid, in_tready, out_tvalid, out_tready;
  logic [31:0]  in_tdata;
  logic [223:0] out_tdata;
  logic [4:0]   out_tuser;
  logic         cfg_wr_en;
  logic [2:0]   cfg_index;
  logic [63:0]  cfg_wdata;
  int           fail_count, pending;
  bit           in_idle, out_idle;

  scaler_channel_running_stats_unit dut (.*);
  scaler_channel_running_stats_unit_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #60000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int gap_len();
    if ($urandom_range(9) < 6) return 0;
    if ($urandom_range(9) < 9) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  // receiver stall, with quiet phases where it never stalls
  initial begin
    int g;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (out_idle) out_tready <= 1'b1;
      else begin
        g = gap_len();
        out_tready <= (g == 0);
        repeat (g > 0 ? g - 1 : 0) @(negedge clk);
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // the unit goes busy when it accepts a word, so the
  // extra falling edge costs no rate
  task automatic send_word(input logic [31:0] w);
    int g;
    g = in_idle ? 0 : gap_len();
    repeat (g + 1) @(negedge clk);
    in_tvalid <= 1'b1; in_tdata <= w;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_raw();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hffff_ffff;
      2: return $urandom_range(0, 64);
      3: return $urandom_range(1000, 1100);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [63:0] rand_wide();
    case ($urandom_range(5))
      0: return 64'd0;
      1: return {1'b0, {63{1'b1}}};
      2: return SIGN64;
      3: return {$urandom(), $urandom()};
      4: return {{24{1'b0}}, 8'($urandom()), $urandom()};
      default: return -{{24{1'b0}}, 8'($urandom()), $urandom()};
    endcase
  endfunction

  initial begin
    logic [63:0] lim;
    in_tvalid = 1'b0; in_tdata = '0;
    cfg_wr_en = 1'b0; cfg_index = '0; cfg_wdata = '0;
    in_idle = 1'b0; out_idle = 1'b0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: defaults, field extremes
    send_word(32'd0);
    send_word(32'hffff_ffff);
    send_word(32'd1);
    send_word(32'h0100_0000);
    drain();
    // zero check, 24-bit mask (top byte only -> zero)
    write_reg(REG_MASK24, 64'd1);
    write_reg(REG_CUT, 64'd1);
    send_word(32'hff00_0000);
    send_word(32'h00ff_ffff);
    drain();
    // window cut: below and inside; max gain, negative pedestal saturate
    write_reg(REG_CUT, 64'd2);
    write_reg(REG_UPPER, 64'h0000_0100_0000_0000);
    write_reg(REG_LOWER, 64'h0000_0000_0010_0000);
    send_word(32'h00ff_ffff);
    send_word(32'd2);
    send_word(32'd100);
    drain();
    write_reg(REG_CUT, 64'd3);
    send_word(32'h00ff_ffff);
    send_word(32'd0);
    drain();
    write_reg(REG_GAIN, 64'hffff_ffff);
    write_reg(REG_PED, SIGN64);
    write_reg(REG_CUT, 64'd0);
    send_word(32'hffff_ffff);
    drain();
    write_reg(REG_PED, {1'b0, {63{1'b1}}});
    send_word(32'd5);
    drain();
    write_reg(REG_ENABLE, 64'd0);
    send_word(32'h1234_5678);
    drain();
    write_reg(REG_UNUSED, 64'hffff_ffff_ffff_ffff);
    write_reg(REG_ENABLE, 64'd1);
    write_reg(REG_PED, 64'd0);
    write_reg(REG_GAIN, {32'd0, GAIN_ONE});
    write_reg(REG_MASK24, 64'd0);
    send_word(32'd7);
    drain();

    // random phases
    for (int ph = 0; ph < 30; ph++) begin
      in_idle = ($urandom_range(4) == 0);
      out_idle = ($urandom_range(4) == 0);
      write_reg(REG_ENABLE, {63'd0, $urandom_range(9) != 0});
      write_reg(REG_MASK24, {63'd0, 1'($urandom())});
      write_reg(REG_PED, ($urandom_range(2) == 0) ? rand_wide()
                                                  : 64'($urandom_range(0, 2000)) << 16);
      case ($urandom_range(4))
        0: write_reg(REG_GAIN, 64'hffff_ffff);
        1: write_reg(REG_GAIN, 64'd0);
        2: write_reg(REG_GAIN, {32'd0, $urandom()});
        default: write_reg(REG_GAIN, 64'($urandom_range(1, 262144)));
      endcase
      write_reg(REG_CUT, 64'($urandom_range(3)));
      if ($urandom_range(4) == 0) begin
        write_reg(REG_UPPER, 64'd0);
        write_reg(REG_LOWER, 64'd0);
      end else begin
        lim = rand_wide();
        write_reg(REG_UPPER, lim);
        write_reg(REG_LOWER, ($urandom_range(2) == 0) ? rand_wide() : lim >>> 2);
      end
      for (int k = 0; k < 60; k++) send_word(rand_raw());
      drain();
    end

    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
